FILE: rtl/gbn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types, codes and helpers of the go-back-n sender.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // input function codes
    localparam logic [1:0] FUNC_SEND = 2'd0;
    localparam logic [1:0] FUNC_ACK  = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;
    localparam logic [1:0] FUNC_RSVD = 2'd3;

    // result kind codes
    localparam logic [2:0] K_SENT        = 3'd0;
    localparam logic [2:0] K_RESENT      = 3'd1;
    localparam logic [2:0] K_REFUSED     = 3'd2;
    localparam logic [2:0] K_ACK_TAKEN   = 3'd3;
    localparam logic [2:0] K_ACK_IGNORED = 3'd4;

    // configuration register indexes
    localparam logic REG_WIN_LEN       = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    localparam logic [3:0]  WIN_LEN_RST       = 4'd4;
    localparam logic [31:0] TIMEOUT_TICKS_RST = 32'd1000;

    // command queue depth, power of two
    localparam int unsigned Q_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_SEND,
        OP_ACK,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [63:0] data;
        logic [7:0]  chk;
        logic [3:0]  ack;
    } t_cmd;

    typedef struct packed {
        logic [3:0]  win_len;
        logic [31:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  seq;
        logic [63:0] frame_data;
        logic [7:0]  checksum;
        logic [3:0]  window_base;
        logic        last;
    } t_rsp;

    typedef enum logic {
        BS_IDLE,
        BS_RESEND
    } t_bstate;

    function automatic logic [7:0] xor_bytes(input logic [63:0] v);
        logic [7:0] c;
        c = 8'd0;
        for (int i = 0; i < 8; i++) begin
            c = c ^ v[8*i +: 8];
        end
        return c;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/gbn_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_in_if
// Input channel: one payload, acknowledgement or timer tick per transfer.
// ----------------------------------------------------------------------------
interface gbn_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [63:0] payload;
    logic [3:0]  ack_seq;

    modport source (output valid, output func, output payload, output ack_seq,
                    input ready);
    modport sink   (input valid, input func, input payload, input ack_seq,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/gbn_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_out_if
// Result channel: one sent, resent, refused or acknowledgement report per transfer.
// ----------------------------------------------------------------------------
interface gbn_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  seq;
    logic [63:0] frame_data;
    logic [7:0]  checksum;
    logic [3:0]  window_base;
    logic        last;

    modport source (output valid, output kind, output seq, output frame_data,
                    output checksum, output window_base, output last,
                    input ready);
    modport sink   (input valid, input kind, input seq, input frame_data,
                    input checksum, input window_base, input last,
                    output ready);
endinterface
`default_nettype wire

FILE: rtl/gbn_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 8
) (
    input  wire  logic                                     i_clk,
    input  wire  logic                                     i_we,
    input  wire  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  logic [WIDTH-1:0]                         i_wdata,
    input  wire  logic                                     i_re,
    input  wire  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                               o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/gbn_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_cfg
// APB register file: window size and timeout limit.
// ----------------------------------------------------------------------------
module gbn_cfg
    import gbn_pkg::*;
(
    input  wire  logic              i_clk,
    input  wire  logic              i_rst_n,
    input  wire  logic              psel,
    input  wire  logic              penable,
    input  wire  logic              pwrite,
    input  wire  logic [APB_AW-1:0] paddr,
    input  wire  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    logic [3:0]  r_win_len;
    logic [31:0] r_timeout_ticks;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len       <= WIN_LEN_RST;
            r_timeout_ticks <= TIMEOUT_TICKS_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_WIN_LEN:       r_win_len       <= pwdata[3:0];
                REG_TIMEOUT_TICKS: r_timeout_ticks <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_WIN_LEN:       prdata = {28'd0, r_win_len};
            REG_TIMEOUT_TICKS: prdata = r_timeout_ticks;
            default:           prdata = '0;
        endcase
    end

    assign o_cfg.win_len       = r_win_len;
    assign o_cfg.timeout_ticks = r_timeout_ticks;

endmodule
`default_nettype wire

FILE: rtl/gbn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_front
// Accepts input transfers, decodes the function and prepares payload and checksum.
// ----------------------------------------------------------------------------
module gbn_front
    import gbn_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = 8
) (
    gbn_in_if.sink i_req,
    input  wire  logic i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    localparam logic [63:0] PAY_MASK = {64{1'b1}} >> (64 - 8 * PAYLOAD_BYTES);

    logic [63:0] data;

    assign data        = i_req.payload & PAY_MASK;
    assign i_req.ready = !i_full;
    // reserved function is taken and dropped
    assign o_push      = i_req.valid && !i_full && (i_req.func != FUNC_RSVD);

    always_comb begin
        case (i_req.func)
            FUNC_SEND: o_cmd.op = OP_SEND;
            FUNC_ACK:  o_cmd.op = OP_ACK;
            FUNC_TICK: o_cmd.op = OP_TICK;
            default:   o_cmd.op = OP_TICK;
        endcase
        o_cmd.data = data;
        o_cmd.chk  = xor_bytes(data);
        o_cmd.ack  = i_req.ack_seq;
    end

endmodule
`default_nettype wire

FILE: rtl/gbn_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module gbn_fifo
    import gbn_pkg::*;
(
    input  wire  logic i_clk,
    input  wire  logic i_rst_n,
    input  wire  logic i_push,
    input  wire  t_cmd i_cmd,
    input  wire  logic i_pop,
    output t_cmd       o_cmd,
    output logic       o_full,
    output logic       o_empty
);

    localparam int unsigned QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_cmd           r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == (QAW + 1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/gbn_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_back
// Window state, frame store, timer and result register; walks the window on timeout.
// ----------------------------------------------------------------------------
module gbn_back
    import gbn_pkg::*;
#(
    parameter int unsigned WINDOW_MAX    = 8,
    parameter int unsigned SEQ_BITS      = 4,
    parameter int unsigned PAYLOAD_BYTES = 8
) (
    input  wire  logic  i_clk,
    input  wire  logic  i_rst_n,
    input  wire  t_cfg  i_cfg,
    input  wire  t_cmd  i_cmd,
    input  wire  logic  i_empty,
    output logic        o_pop,
    gbn_out_if.source   o_rsp
);

    localparam int unsigned SEQ_MOD = 1 << SEQ_BITS;
    localparam int unsigned WIN_CAP = (WINDOW_MAX < SEQ_MOD - 1) ? WINDOW_MAX : SEQ_MOD - 1;
    localparam int unsigned SW      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int unsigned EW      = (SEQ_BITS > 4) ? SEQ_BITS : 4;
    localparam int unsigned AW      = ((SW > SEQ_BITS) ? SW : SEQ_BITS) + 1;
    localparam int unsigned DW      = 8 * PAYLOAD_BYTES;

    typedef logic [SEQ_BITS-1:0] t_seq;
    typedef logic [SW-1:0]       t_slot;
    typedef logic [EW-1:0]       t_ew;
    typedef logic [AW-1:0]       t_aw;
    typedef logic [DW-1:0]       t_dw;

    function automatic t_slot slot_inc(input t_slot s);
        return (s == t_slot'(WINDOW_MAX - 1)) ? '0 : s + 1'b1;
    endfunction

    t_bstate     r_state, n_state;
    t_seq        r_base, n_base;
    t_seq        r_next, n_next;
    t_slot       r_base_slot, n_base_slot;
    t_slot       r_next_slot, n_next_slot;
    logic [31:0] r_idle, n_idle;
    t_slot       r_walk_slot, n_walk_slot;
    t_seq        r_walk_cnt, n_walk_cnt;
    logic        r_out_valid, n_out_valid;
    t_rsp        r_out, n_out;

    t_seq        outstanding;
    t_ew         win_raw;
    t_ew         eff_win;
    logic        win_full;
    t_seq        ack_a;
    t_seq        ack_off;
    logic        ack_hit;
    t_seq        ack_base;
    t_aw         slot_sum;
    t_slot       ack_slot;
    logic [31:0] limit;
    logic [31:0] idle_inc;
    logic        timeout_hit;
    logic        out_free;
    logic        walk_last;
    logic        ram_we;
    logic        ram_re;
    t_slot       ram_raddr;
    t_dw         ram_rdata;
    logic [63:0] rd_data;

    gbn_ram #(
        .WIDTH (DW),
        .DEPTH (WINDOW_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_next_slot),
        .i_wdata (t_dw'(i_cmd.data)),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign outstanding = r_next - r_base;
    assign win_raw     = t_ew'(i_cfg.win_len);
    assign eff_win     = (win_raw == '0) ? t_ew'(1) :
                         (win_raw > t_ew'(WIN_CAP)) ? t_ew'(WIN_CAP) : win_raw;
    assign win_full    = t_ew'(outstanding) >= eff_win;

    assign ack_a    = t_seq'(i_cmd.ack);
    assign ack_off  = ack_a - r_base;
    assign ack_hit  = ack_off < outstanding;
    assign ack_base = ack_a + 1'b1;
    // base slot moves by the number of frames acknowledged
    assign slot_sum = t_aw'(r_base_slot) + t_aw'(t_seq'(ack_off + 1'b1));
    assign ack_slot = (slot_sum >= t_aw'(WINDOW_MAX)) ? t_slot'(slot_sum - t_aw'(WINDOW_MAX))
                                                      : t_slot'(slot_sum);

    assign limit       = (i_cfg.timeout_ticks == '0) ? 32'd1 : i_cfg.timeout_ticks;
    assign idle_inc    = (r_idle == '1) ? r_idle : r_idle + 32'd1;
    assign timeout_hit = idle_inc >= limit;

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign walk_last = t_seq'(r_walk_cnt + 1'b1) == outstanding;
    assign rd_data   = 64'(ram_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_base      <= '0;
            r_next      <= '0;
            r_base_slot <= '0;
            r_next_slot <= '0;
            r_idle      <= '0;
            r_walk_slot <= '0;
            r_walk_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_next      <= n_next;
            r_base_slot <= n_base_slot;
            r_next_slot <= n_next_slot;
            r_idle      <= n_idle;
            r_walk_slot <= n_walk_slot;
            r_walk_cnt  <= n_walk_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_next      = r_next;
        n_base_slot = r_base_slot;
        n_next_slot = r_next_slot;
        n_idle      = r_idle;
        n_walk_slot = r_walk_slot;
        n_walk_cnt  = r_walk_cnt;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out       = r_out;
        o_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_base_slot;

        case (r_state)
            BS_IDLE: begin
                if (!i_empty && out_free) begin
                    o_pop            = 1'b1;
                    n_out.seq        = '0;
                    n_out.frame_data = '0;
                    n_out.checksum   = '0;
                    n_out.window_base = 4'(r_base);
                    n_out.last       = 1'b1;
                    case (i_cmd.op)
                        OP_SEND: begin
                            n_out_valid = 1'b1;
                            if (win_full) begin
                                n_out.kind = K_REFUSED;
                            end else begin
                                ram_we           = 1'b1;
                                n_next           = r_next + 1'b1;
                                n_next_slot      = slot_inc(r_next_slot);
                                n_out.kind       = K_SENT;
                                n_out.seq        = 4'(r_next);
                                n_out.frame_data = i_cmd.data;
                                n_out.checksum   = i_cmd.chk;
                                if (outstanding == '0) begin
                                    n_idle = '0;
                                end
                            end
                        end
                        OP_ACK: begin
                            n_out_valid = 1'b1;
                            if (ack_hit) begin
                                n_base            = ack_base;
                                n_base_slot       = ack_slot;
                                n_idle            = '0;
                                n_out.kind        = K_ACK_TAKEN;
                                n_out.window_base = 4'(ack_base);
                            end else begin
                                n_out.kind = K_ACK_IGNORED;
                            end
                        end
                        OP_TICK: begin
                            if (outstanding == '0) begin
                                n_idle = '0;
                            end else if (timeout_hit) begin
                                n_idle      = '0;
                                ram_re      = 1'b1;
                                ram_raddr   = r_base_slot;
                                n_walk_slot = r_base_slot;
                                n_walk_cnt  = '0;
                                n_state     = BS_RESEND;
                            end else begin
                                n_idle = idle_inc;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BS_RESEND: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.kind        = K_RESENT;
                    n_out.seq         = 4'(t_seq'(r_base + r_walk_cnt));
                    n_out.frame_data  = rd_data;
                    n_out.checksum    = xor_bytes(rd_data);
                    n_out.window_base = 4'(r_base);
                    n_out.last        = walk_last;
                    if (walk_last) begin
                        n_state = BS_IDLE;
                    end else begin
                        // fetch the next frame while this one goes out
                        ram_re      = 1'b1;
                        ram_raddr   = slot_inc(r_walk_slot);
                        n_walk_slot = slot_inc(r_walk_slot);
                        n_walk_cnt  = r_walk_cnt + 1'b1;
                    end
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.kind        = r_out.kind;
    assign o_rsp.seq         = r_out.seq;
    assign o_rsp.frame_data  = r_out.frame_data;
    assign o_rsp.checksum    = r_out.checksum;
    assign o_rsp.window_base = r_out.window_base;
    assign o_rsp.last        = r_out.last;

endmodule
`default_nettype wire

FILE: rtl/go_back_n_sender_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// go_back_n_sender_top
// Go-back-n sender: sends, acknowledges and resends frames of a sliding window.
// ----------------------------------------------------------------------------
// Items enter through a two-entry command queue; the back end then takes one
// queued item per cycle when its result register is free and no resend runs;
// a send or an ACK gives a result, a tick without timeout none. A timeout
// resends the outstanding frames from the base onward, one frame per cycle
// while the result register is free, out of the frame store's single
// registered read port; the first read starts as the timeout is taken. No
// clearing pass is needed after reset.
module go_back_n_sender_top
    import gbn_pkg::*;
#(
    parameter int unsigned WINDOW_MAX    = 8,
    parameter int unsigned SEQ_BITS      = 4,
    parameter int unsigned PAYLOAD_BYTES = 8
) (
    input  wire  logic              i_clk,
    input  wire  logic              i_rst_n,
    gbn_in_if.sink                  i_req,
    gbn_out_if.source               o_rsp,
    input  wire  logic              psel,
    input  wire  logic              penable,
    input  wire  logic              pwrite,
    input  wire  logic [APB_AW-1:0] paddr,
    input  wire  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready
);

    t_cfg cfg;
    t_cmd push_cmd;
    t_cmd pop_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    gbn_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    gbn_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_front (
        .i_req  (i_req),
        .i_full (q_full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    gbn_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    gbn_back #(
        .WINDOW_MAX    (WINDOW_MAX),
        .SEQ_BITS      (SEQ_BITS),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_cmd   (pop_cmd),
        .i_empty (q_empty),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.kind <= K_ACK_IGNORED))
        else $error("result kind out of range");

    a_no_frame_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.kind == K_REFUSED || o_rsp.kind == K_ACK_TAKEN ||
                        o_rsp.kind == K_ACK_IGNORED)
        |-> (o_rsp.seq == '0 && o_rsp.frame_data == '0 && o_rsp.checksum == '0))
        else $error("frame fields set on a report without a frame");

    a_checksum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.checksum == xor_bytes(o_rsp.frame_data)))
        else $error("checksum does not match frame data");

    a_resend_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.ready && o_rsp.kind == K_RESENT && !o_rsp.last
        |=> o_rsp.valid && o_rsp.kind == K_RESENT && $stable(o_rsp.window_base))
        else $error("resend burst broken");

endmodule
`default_nettype wire

FILE: verif/go_back_n_sender_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// go_back_n_sender_top_tb
// Self-checking bench for the go-back-n sender. A directed table covers the
// window and timer limits, refusals, stale and wrapped ACKs and a full resend.
// Random traffic then runs over several window and timeout settings. Every
// report is checked against the table's own report or the bench's model of
// the window, the timer and the frame store.
// ----------------------------------------------------------------------------
module go_back_n_sender_top_tb;
    import gbn_pkg::*;

    localparam logic [3:0] WIN_CAP = 4'd8;
    localparam int WIN_SLOTS = 8;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES = 7;
    localparam int PHASE_ITEMS = 20;

    typedef struct {
        logic        is_cfg;
        logic        reg_idx;
        logic [31:0] cfg_val;
        logic [1:0]  func;
        logic [63:0] payload;
        logic [3:0]  ack_seq;
        logic        typed;
        t_rsp        report;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    gbn_in_if  req_if ();
    gbn_out_if rsp_if ();

    // sender state as tracked by the bench
    logic [3:0]  win_size;
    logic [31:0] timeout_lim;
    logic [3:0]  base_seq;
    logic [3:0]  next_seq;
    logic [31:0] idle_ticks;
    logic [63:0] frame_store [WIN_SLOTS];
    t_rsp        awaited_reports [$];

    bit steady;
    int mismatches = 0;
    int cycles = 0;

    go_back_n_sender_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [7:0] fold_checksum(input logic [63:0] v);
        logic [31:0] w;
        logic [15:0] h;
        w = v[63:32] ^ v[31:0];
        h = w[31:16] ^ w[15:0];
        return h[15:8] ^ h[7:0];
    endfunction

    function automatic void queue_report(input bit keep, input logic [2:0] kind,
            input logic [3:0] seq, input logic [63:0] data, input logic last);
        t_rsp r;
        r.kind        = kind;
        r.seq         = seq;
        r.frame_data  = data;
        r.checksum    = fold_checksum(data);
        r.window_base = base_seq;
        r.last        = last;
        if (keep) begin
            awaited_reports.push_back(r);
        end
    endfunction

    // advance the tracked sender by one accepted transfer
    function automatic void step_sender(input logic [1:0] func, input logic [63:0] payload,
            input logic [3:0] ack_seq, input bit keep);
        logic [3:0]  outst;
        logic [3:0]  eff;
        logic [3:0]  gap;
        logic [3:0]  s;
        logic [31:0] lim;
        outst = next_seq - base_seq;
        eff = (win_size == 4'd0) ? 4'd1 : (win_size > WIN_CAP) ? WIN_CAP : win_size;
        case (func)
            FUNC_SEND: begin
                if (outst >= eff) begin
                    queue_report(keep, K_REFUSED, 4'd0, 64'd0, 1'b1);
                end else begin
                    frame_store[next_seq[2:0]] = payload;
                    if (outst == 4'd0) begin
                        idle_ticks = 32'd0;
                    end
                    queue_report(keep, K_SENT, next_seq, payload, 1'b1);
                    next_seq = next_seq + 4'd1;
                end
            end
            FUNC_ACK: begin
                gap = ack_seq - base_seq;
                if (gap < outst) begin
                    base_seq = ack_seq + 4'd1;
                    idle_ticks = 32'd0;
                    queue_report(keep, K_ACK_TAKEN, 4'd0, 64'd0, 1'b1);
                end else begin
                    queue_report(keep, K_ACK_IGNORED, 4'd0, 64'd0, 1'b1);
                end
            end
            FUNC_TICK: begin
                if (outst == 4'd0) begin
                    idle_ticks = 32'd0;
                end else begin
                    if (idle_ticks != 32'hFFFF_FFFF) begin
                        idle_ticks = idle_ticks + 32'd1;
                    end
                    lim = (timeout_lim == 32'd0) ? 32'd1 : timeout_lim;
                    if (idle_ticks >= lim) begin
                        idle_ticks = 32'd0;
                        for (int i = 0; i < outst; i++) begin
                            s = base_seq + 4'(i);
                            queue_report(keep, K_RESENT, s, frame_store[s[2:0]],
                                         i + 1 == outst);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_row item_row(input logic [1:0] func, input logic [63:0] payload,
            input logic [3:0] ack_seq);
        t_row r;
        r = '{is_cfg: 1'b0, reg_idx: REG_WIN_LEN, cfg_val: 32'd0, func: func,
              payload: payload, ack_seq: ack_seq, typed: 1'b0, report: '0};
        return r;
    endfunction

    function automatic t_row known_row(input logic [1:0] func, input logic [63:0] payload,
            input logic [3:0] ack_seq, input logic [2:0] kind, input logic [3:0] wbase);
        t_row r;
        r = item_row(func, payload, ack_seq);
        r.typed = 1'b1;
        r.report = '{kind: kind, seq: 4'd0, frame_data: 64'd0, checksum: 8'd0,
                     window_base: wbase, last: 1'b1};
        return r;
    endfunction

    function automatic t_row cfg_row(input logic reg_idx, input logic [31:0] val);
        t_row r;
        r = item_row(FUNC_RSVD, 64'd0, 4'd0);
        r.is_cfg = 1'b1;
        r.reg_idx = reg_idx;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic void note_mismatch(input string what, input logic [63:0] want,
            input logic [63:0] got);
        if (mismatches < 10) begin
            $display("mismatch in %s: expected %h, got %h", what, want, got);
        end
        mismatches++;
    endfunction

    function automatic void check_field(input string what, input logic [63:0] want,
            input logic [63:0] got);
        if (want !== got) begin
            note_mismatch(what, want, got);
        end
    endfunction

    task automatic send_item(input logic [1:0] func, input logic [63:0] payload,
            input logic [3:0] ack_seq, input bit keep);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 26) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.func    <= func;
        req_if.payload <= payload;
        req_if.ack_seq <= ack_seq;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        step_sender(func, payload, ack_seq, keep);
    endtask

    // let every awaited report arrive and the back end go quiet
    task automatic settle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (reg_idx == REG_WIN_LEN) begin
            win_size = val[3:0];
        end else begin
            timeout_lim = val;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        rsp_if.ready <= steady || ($urandom_range(99) >= 26);
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (awaited_reports.size() == 0) begin
                note_mismatch("unawaited report kind", 64'd0, 64'(rsp_if.kind));
            end else begin
                want = awaited_reports.pop_front();
                check_field("kind", 64'(want.kind), 64'(rsp_if.kind));
                check_field("seq", 64'(want.seq), 64'(rsp_if.seq));
                check_field("frame_data", want.frame_data, rsp_if.frame_data);
                check_field("checksum", 64'(want.checksum), 64'(rsp_if.checksum));
                check_field("window_base", 64'(want.window_base), 64'(rsp_if.window_base));
                check_field("last", 64'(want.last), 64'(rsp_if.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("go_back_n_sender_top_tb failed");
            $finish;
        end
    end

    initial begin
        t_row        plan [$];
        logic [1:0]  func;
        logic [63:0] payload;
        logic [3:0]  ack_seq;
        logic [3:0]  outst;
        int          count;
        int          r;

        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        req_if.valid   = 1'b0;
        req_if.func    = FUNC_SEND;
        req_if.payload = 64'd0;
        req_if.ack_seq = 4'd0;
        steady      = 1'b0;
        win_size    = WIN_LEN_RST;
        timeout_lim = TIMEOUT_TICKS_RST;
        base_seq    = 4'd0;
        next_seq    = 4'd0;
        idle_ticks  = 32'd0;
        foreach (frame_store[k]) frame_store[k] = 64'd0;

        plan = '{
            known_row(FUNC_ACK,  64'd0, 4'd0, K_ACK_IGNORED, 4'd0),
            item_row (FUNC_TICK, 64'd0, 4'd0),
            known_row(FUNC_SEND, 64'd0, 4'd0, K_SENT, 4'd0),
            item_row (FUNC_SEND, '1, 4'hF),
            item_row (FUNC_SEND, 64'h0102_0304_0506_0708, 4'd0),
            item_row (FUNC_SEND, 64'h8000_0000_0000_0001, 4'd0),
            known_row(FUNC_SEND, 64'h0000_0000_0000_DEAD, 4'd0, K_REFUSED, 4'd0),
            known_row(FUNC_ACK,  64'd0, 4'd15, K_ACK_IGNORED, 4'd0),
            known_row(FUNC_ACK,  64'd0, 4'd1, K_ACK_TAKEN, 4'd2),
            cfg_row  (REG_TIMEOUT_TICKS, 32'd1),
            item_row (FUNC_TICK, 64'd0, 4'd0),
            cfg_row  (REG_WIN_LEN, 32'd0),
            known_row(FUNC_SEND, 64'h0000_0000_0000_1234, 4'd0, K_REFUSED, 4'd2),
            known_row(FUNC_ACK,  64'd0, 4'd3, K_ACK_TAKEN, 4'd4),
            item_row (FUNC_SEND, 64'h00FF_00FF_00FF_00FF, 4'd0),
            known_row(FUNC_SEND, 64'h0000_0000_0000_0077, 4'd0, K_REFUSED, 4'd4),
            item_row (FUNC_RSVD, '1, 4'hF),
            cfg_row  (REG_WIN_LEN, 32'd15),
            cfg_row  (REG_TIMEOUT_TICKS, 32'd0),
            item_row (FUNC_SEND, 64'hFEDC_BA98_7654_3210, 4'd0),
            item_row (FUNC_SEND, 64'h5555_5555_5555_5555, 4'd0),
            item_row (FUNC_SEND, 64'hAAAA_AAAA_AAAA_AAAA, 4'd0),
            item_row (FUNC_SEND, 64'h0000_0000_FFFF_FFFF, 4'd0),
            item_row (FUNC_SEND, 64'hFFFF_FFFF_0000_0000, 4'd0),
            item_row (FUNC_SEND, 64'h1111_2222_3333_4444, 4'd0),
            item_row (FUNC_SEND, 64'h0123_4567_89AB_CDEF, 4'd0),
            known_row(FUNC_SEND, 64'h0000_0000_0000_005A, 4'd0, K_REFUSED, 4'd4),
            item_row (FUNC_TICK, 64'd0, 4'd0),
            cfg_row  (REG_TIMEOUT_TICKS, 32'hFFFF_FFFF),
            item_row (FUNC_TICK, 64'd0, 4'd0),
            known_row(FUNC_ACK,  64'd0, 4'd11, K_ACK_TAKEN, 4'd12)
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].is_cfg) begin
                settle();
                write_reg(plan[n].reg_idx, plan[n].cfg_val);
            end else begin
                send_item(plan[n].func, plan[n].payload, plan[n].ack_seq, !plan[n].typed);
                if (plan[n].typed) begin
                    awaited_reports.push_back(plan[n].report);
                end
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            settle();
            write_reg(REG_WIN_LEN, (p == 0) ? 32'd1 : (p == 1) ? 32'd8 :
                      (p == 5) ? 32'd0 : 32'($urandom_range(15)));
            write_reg(REG_TIMEOUT_TICKS, (p == 2) ? 32'hFFFF_FFFF : 32'($urandom_range(6)));
            steady = (p == 3);
            count = 0;
            while (count < PHASE_ITEMS) begin
                outst = next_seq - base_seq;
                r = $urandom_range(9);
                payload = (r == 0) ? 64'd0 : (r == 1) ? '1 : {$urandom, $urandom};
                ack_seq = 4'($urandom_range(15));
                r = $urandom_range(99);
                if (r < 40) begin
                    func = FUNC_SEND;
                end else if (r < 70) begin
                    func = FUNC_ACK;
                    // mostly ACKs that land inside the outstanding range
                    if (outst != 4'd0 && $urandom_range(3) != 0) begin
                        ack_seq = base_seq + 4'($urandom_range(outst - 1));
                    end
                end else if (r < 95) begin
                    func = FUNC_TICK;
                end else begin
                    func = FUNC_RSVD;
                end
                if (func != FUNC_RSVD) begin
                    count++;
                end
                send_item(func, payload, ack_seq, 1'b1);
            end
        end
        steady = 1'b0;

        settle();
        if (mismatches == 0 && awaited_reports.size() == 0) begin
            $display("go_back_n_sender_top_tb passed");
        end else begin
            $display("go_back_n_sender_top_tb failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
